### rtl/jsee_pkg.sv
package jsee_pkg;

    // What the body of one input byte expands to.
    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_PLAIN = 3'd1,
        KIND_PAIR  = 3'd2,
        KIND_HEX   = 3'd3,
        KIND_HEX2  = 3'd4,
        KIND_BAD   = 3'd5
    } kind_t;

    localparam int unsigned NUM_SLOTS = 17;

    // Fixed output schedule of one job; unused slots are skipped.
    localparam logic [4:0] SLOT_PRE_BAD   = 5'd0;
    localparam logic [4:0] SLOT_OPEN      = 5'd1;
    localparam logic [4:0] SLOT_MID_BAD   = 5'd2;
    localparam logic [4:0] SLOT_BODY0     = 5'd3;
    localparam logic [4:0] SLOT_BODY1     = 5'd4;
    localparam logic [4:0] SLOT_HI_D3     = 5'd5;
    localparam logic [4:0] SLOT_HI_D2     = 5'd6;
    localparam logic [4:0] SLOT_HI_D1     = 5'd7;
    localparam logic [4:0] SLOT_HI_D0     = 5'd8;
    localparam logic [4:0] SLOT_LO_BSLASH = 5'd9;
    localparam logic [4:0] SLOT_LO_U      = 5'd10;
    localparam logic [4:0] SLOT_LO_D3     = 5'd11;
    localparam logic [4:0] SLOT_LO_D2     = 5'd12;
    localparam logic [4:0] SLOT_LO_D1     = 5'd13;
    localparam logic [4:0] SLOT_LO_D0     = 5'd14;
    localparam logic [4:0] SLOT_LAST_BAD  = 5'd15;
    localparam logic [4:0] SLOT_CLOSE     = 5'd16;

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CHAR_B      = 8'h62;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;

    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_TAB = 8'h09;
    localparam logic [7:0] CTRL_LF  = 8'h0A;
    localparam logic [7:0] CTRL_FF  = 8'h0C;
    localparam logic [7:0] CTRL_CR  = 8'h0D;

    localparam logic [20:0] CP_BMP_END = 21'h010000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [5:0]  SURR_HI    = 6'b110110;
    localparam logic [5:0]  SURR_LO    = 6'b110111;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;
        kind_t                kind;
        logic [15:0]          hi;
        logic [15:0]          lo;
    } job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'h0, nib};
        hex_char = (nib < 4'd10) ? 8'h30 + ext : 8'h37 + ext;
    endfunction

endpackage

### rtl/jsee_front.sv
module jsee_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                first_of_string,
    input  logic                last_of_string,
    output logic                push,
    output jsee_pkg::job_t      job
);

    logic [20:0] partial_reg, partial_next;
    logic [1:0]  remain_reg, remain_next;

    logic [1:0]  rem_eff;
    logic        pre_bad, mid_bad, last_bad, cont;
    logic [20:0] pc_new;
    logic [19:0] pc_off;
    logic [20:0] part_mid;
    logic [1:0]  rem_mid;
    logic [7:0]  esc;
    jsee_pkg::kind_t kind;
    logic [15:0] hi, lo;
    logic [jsee_pkg::NUM_SLOTS-1:0] slots;

    always_comb begin
        rem_eff  = first_of_string ? 2'd0 : remain_reg;
        pre_bad  = first_of_string && (remain_reg != 2'd0);
        cont     = (rem_eff != 2'd0) && (in_byte[7:6] == 2'b10);
        pc_new   = {partial_reg[14:0], in_byte[5:0]};
        pc_off   = 20'(pc_new - jsee_pkg::CP_BMP_END);
        mid_bad  = 1'b0;
        kind     = jsee_pkg::KIND_NONE;
        hi       = 16'h0000;
        lo       = {jsee_pkg::SURR_LO, pc_off[9:0]};
        part_mid = 21'd0;
        rem_mid  = 2'd0;
        esc      = 8'h00;

        if (cont) begin
            rem_mid = rem_eff - 2'd1;
            if (rem_mid == 2'd0) begin
                if (pc_new < jsee_pkg::CP_BMP_END) begin
                    kind = jsee_pkg::KIND_HEX;
                    hi   = pc_new[15:0];
                end else if (pc_new <= jsee_pkg::CP_MAX) begin
                    kind = jsee_pkg::KIND_HEX2;
                    hi   = {jsee_pkg::SURR_HI, pc_off[19:10]};
                end else begin
                    kind = jsee_pkg::KIND_BAD;
                end
            end else begin
                part_mid = pc_new;
            end
        end else begin
            // A pending sequence cut short by a non-continuation byte.
            mid_bad = (rem_eff != 2'd0);
            if (!in_byte[7]) begin
                case (in_byte)
                    jsee_pkg::CHAR_BSLASH: esc = jsee_pkg::CHAR_BSLASH;
                    jsee_pkg::CHAR_QUOTE:  esc = jsee_pkg::CHAR_QUOTE;
                    jsee_pkg::CHAR_SLASH:  esc = jsee_pkg::CHAR_SLASH;
                    jsee_pkg::CTRL_BS:     esc = jsee_pkg::CHAR_B;
                    jsee_pkg::CTRL_FF:     esc = jsee_pkg::CHAR_F;
                    jsee_pkg::CTRL_LF:     esc = jsee_pkg::CHAR_N;
                    jsee_pkg::CTRL_CR:     esc = jsee_pkg::CHAR_R;
                    jsee_pkg::CTRL_TAB:    esc = jsee_pkg::CHAR_T;
                    default:               esc = 8'h00;
                endcase
                if (esc != 8'h00) begin
                    kind = jsee_pkg::KIND_PAIR;
                    hi   = {8'h00, esc};
                end else if (in_byte < 8'h20) begin
                    kind = jsee_pkg::KIND_HEX;
                    hi   = {8'h00, in_byte};
                end else begin
                    kind = jsee_pkg::KIND_PLAIN;
                    hi   = {8'h00, in_byte};
                end
            end else if (in_byte[7:5] == 3'b110) begin
                part_mid = {16'd0, in_byte[4:0]};
                rem_mid  = 2'd1;
            end else if (in_byte[7:4] == 4'b1110) begin
                part_mid = {17'd0, in_byte[3:0]};
                rem_mid  = 2'd2;
            end else if (in_byte[7:3] == 5'b11110) begin
                part_mid = {18'd0, in_byte[2:0]};
                rem_mid  = 2'd3;
            end else begin
                kind = jsee_pkg::KIND_BAD;
            end
        end

        last_bad     = last_of_string && (rem_mid != 2'd0);
        partial_next = last_of_string ? 21'd0 : part_mid;
        remain_next  = last_of_string ? 2'd0 : rem_mid;

        slots        = '0;
        slots[jsee_pkg::SLOT_PRE_BAD] = pre_bad;
        slots[jsee_pkg::SLOT_OPEN]    = first_of_string;
        slots[jsee_pkg::SLOT_MID_BAD] = mid_bad;
        slots[jsee_pkg::SLOT_BODY0]   = (kind != jsee_pkg::KIND_NONE);
        slots[jsee_pkg::SLOT_BODY1]   = (kind == jsee_pkg::KIND_PAIR) ||
                                        (kind == jsee_pkg::KIND_HEX) ||
                                        (kind == jsee_pkg::KIND_HEX2);
        slots[jsee_pkg::SLOT_HI_D0:jsee_pkg::SLOT_HI_D3] =
            ((kind == jsee_pkg::KIND_HEX) || (kind == jsee_pkg::KIND_HEX2)) ? 4'hF : 4'h0;
        slots[jsee_pkg::SLOT_LO_D0:jsee_pkg::SLOT_LO_BSLASH] =
            (kind == jsee_pkg::KIND_HEX2) ? 6'h3F : 6'h00;
        slots[jsee_pkg::SLOT_LAST_BAD] = last_bad;
        slots[jsee_pkg::SLOT_CLOSE]    = last_of_string;

        job.slots = slots;
        job.kind  = kind;
        job.hi    = hi;
        job.lo    = lo;
        push      = accept && (slots != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= 21'd0;
            remain_reg  <= 2'd0;
        end else if (accept) begin
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
        end
    end

    // A string end always leaves the decoder with nothing pending.
    a_clear_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_of_string) |=> (remain_reg == 2'd0 && partial_reg == 21'd0))
        else $error("decoder state not cleared at string end");

endmodule

### rtl/jsee_queue.sv
module jsee_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  jsee_pkg::job_t      push_job,
    output logic                ready,
    output logic                pop_valid,
    input  logic                pop_ready,
    output jsee_pkg::job_t      pop_job
);

    jsee_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    always_comb begin
        ready       = (count_reg != 2'd2);
        pop_valid   = (count_reg != 2'd0);
        pop_job     = entry_reg[rd_ptr_reg];
        pop         = pop_valid && pop_ready;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> !push)
        else $error("job queue written while full");

endmodule

### rtl/jsee_back.sv
module jsee_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  jsee_pkg::job_t      job,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last,
    output logic                out_bad
);

    logic           cur_valid_reg, cur_valid_next;
    jsee_pkg::job_t cur_reg, cur_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_byte_reg, out_byte_next;
    logic           out_last_reg, out_last_next;
    logic           out_bad_reg, out_bad_next;

    logic [jsee_pkg::NUM_SLOTS-1:0] rest;
    logic [4:0]  idx;
    logic        emit, done, load;
    logic [7:0]  sel_byte;
    logic        sel_bad;

    always_comb begin
        idx = '0;
        for (int i = jsee_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (cur_reg.slots[i]) begin
                idx = 5'(i);
            end
        end
        rest = cur_reg.slots & (cur_reg.slots - 1'b1);

        sel_bad  = 1'b0;
        sel_byte = 8'h00;
        case (idx)
            jsee_pkg::SLOT_PRE_BAD,
            jsee_pkg::SLOT_MID_BAD,
            jsee_pkg::SLOT_LAST_BAD: sel_bad = 1'b1;
            jsee_pkg::SLOT_OPEN,
            jsee_pkg::SLOT_CLOSE:    sel_byte = jsee_pkg::CHAR_QUOTE;
            jsee_pkg::SLOT_BODY0: begin
                if (cur_reg.kind == jsee_pkg::KIND_PLAIN) begin
                    sel_byte = cur_reg.hi[7:0];
                end else if (cur_reg.kind == jsee_pkg::KIND_BAD) begin
                    sel_bad = 1'b1;
                end else begin
                    sel_byte = jsee_pkg::CHAR_BSLASH;
                end
            end
            jsee_pkg::SLOT_BODY1: begin
                sel_byte = (cur_reg.kind == jsee_pkg::KIND_PAIR) ? cur_reg.hi[7:0]
                                                                 : jsee_pkg::CHAR_U;
            end
            jsee_pkg::SLOT_HI_D3:     sel_byte = jsee_pkg::hex_char(cur_reg.hi[15:12]);
            jsee_pkg::SLOT_HI_D2:     sel_byte = jsee_pkg::hex_char(cur_reg.hi[11:8]);
            jsee_pkg::SLOT_HI_D1:     sel_byte = jsee_pkg::hex_char(cur_reg.hi[7:4]);
            jsee_pkg::SLOT_HI_D0:     sel_byte = jsee_pkg::hex_char(cur_reg.hi[3:0]);
            jsee_pkg::SLOT_LO_BSLASH: sel_byte = jsee_pkg::CHAR_BSLASH;
            jsee_pkg::SLOT_LO_U:      sel_byte = jsee_pkg::CHAR_U;
            jsee_pkg::SLOT_LO_D3:     sel_byte = jsee_pkg::hex_char(cur_reg.lo[15:12]);
            jsee_pkg::SLOT_LO_D2:     sel_byte = jsee_pkg::hex_char(cur_reg.lo[11:8]);
            jsee_pkg::SLOT_LO_D1:     sel_byte = jsee_pkg::hex_char(cur_reg.lo[7:4]);
            jsee_pkg::SLOT_LO_D0:     sel_byte = jsee_pkg::hex_char(cur_reg.lo[3:0]);
            default:                  sel_byte = 8'h00;
        endcase

        // The output register takes a byte from the current job whenever it is empty or being drained.
        emit      = cur_valid_reg && (!out_valid_reg || out_ready);
        done      = emit && (rest == '0);
        job_ready = !cur_valid_reg || done;
        load      = job_ready && job_valid;

        cur_valid_next = load ? 1'b1 : (done ? 1'b0 : cur_valid_reg);
        cur_next       = cur_reg;
        if (load) begin
            cur_next = job;
        end else if (emit) begin
            cur_next.slots = rest;
        end

        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        out_byte_next  = emit ? sel_byte : out_byte_reg;
        out_last_next  = emit ? (rest == '0) : out_last_reg;
        out_bad_next   = emit ? sel_bad : out_bad_reg;

        out_valid = out_valid_reg;
        out_byte  = out_byte_reg;
        out_last  = out_last_reg;
        out_bad   = out_bad_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    a_job_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (cur_reg.slots != '0))
        else $error("active job has no output left");

    a_bad_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_bad_reg) |-> (out_byte_reg == 8'h00))
        else $error("error marker carries a data byte");

endmodule

### rtl/json_string_escape_encoder_core.sv
// Channel   Direction  tdata                tuser              tlast
// s_axis    in         [7:0] in_byte        first_of_string    last_of_string
// m_axis    out        [7:0] out_byte       bad_sequence       run_end
//
// The front decodes one input byte per cycle while s_tready is high, queuing a job
// (two entries) for each byte that yields output (0 to 13 bytes). The back drains
// one output byte per cycle from the current job while m_tready is high.
// Bytes that yield one output byte flow at one per cycle while m_tready is high.
// Reset is synchronous; no clearing pass is needed after it.
// m_tready low stalls the back, and s_tready falls only once the queue is full.
module json_string_escape_encoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] first_of_string
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] bad_sequence
    output logic       m_tlast
);

    logic           accept;
    logic           push;
    jsee_pkg::job_t push_job;
    logic           q_valid, q_ready;
    jsee_pkg::job_t q_job;

    assign accept = s_tvalid && s_tready;

    jsee_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .in_byte         (s_tdata),
        .first_of_string (s_tuser),
        .last_of_string  (s_tlast),
        .push            (push),
        .job             (push_job)
    );

    jsee_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .ready     (s_tready),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_job   (q_job)
    );

    jsee_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_bad   (m_tuser)
    );

endmodule
